>>> src/lrp_pkg.sv
// shared constants, codes and controller/datapath interface types for the
// lfu replacement tracker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrp_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int SCAN_W  = IDX_W + 1;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 48;
    localparam int REC_W   = KEY_W + CNT_W + STAMP_W;
    localparam int OP_W    = 2;
    localparam int ST_W    = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [OP_W-1:0] OP_HIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd3;
    localparam logic [ST_W-1:0] ST_DUP    = 3'd4;

    typedef struct packed {
        logic start;
        logic scan;
        logic update;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/lrp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/lrp_ctrl.sv
// controller state machine: sequences accept, slot scan, update and result
// depends on lrp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrp_ctrl
    import lrp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.load_out = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // wait here until the output register is free
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> src/lrp_datapath.sv
// datapath: slot record ram, valid bits, stamp counter, scan registers,
// update logic and output registers; depends on lrp_pkg and lrp_ram
`timescale 1ns / 1ps
`default_nettype none

module lrp_datapath
    import lrp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [KEY_W-1:0] i_key,
    output logic      [KEY_W-1:0] o_evicted_key,
    output logic      [ST_W-1:0]  o_status
);

    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [SLOTS-1:0]   r_slot_valid;
    logic [STAMP_W-1:0] r_stamp_ctr;

    logic [SCAN_W-1:0]  r_rd_ptr;
    logic [IDX_W-1:0]   r_dat_idx;
    logic               r_dat_vld;

    logic               r_hit_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [CNT_W-1:0]   r_hit_cnt;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_best_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [CNT_W-1:0]   r_best_cnt;
    logic [STAMP_W-1:0] r_best_stamp;
    logic [KEY_W-1:0]   r_best_key;

    logic [KEY_W-1:0]   r_res_key;
    logic [ST_W-1:0]    r_res_status;
    logic [KEY_W-1:0]   r_out_key;
    logic [ST_W-1:0]    r_out_status;

    logic               issue_rd;
    logic [REC_W-1:0]   rd_rec;
    logic [KEY_W-1:0]   rec_key;
    logic [CNT_W-1:0]   rec_cnt;
    logic [STAMP_W-1:0] rec_stamp;
    logic               rec_valid;
    logic               take_best;

    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [REC_W-1:0]   wdata;
    logic [CNT_W-1:0]   cnt_next;
    logic               set_valid;
    logic               clr_valid;
    logic               bump_stamp;
    logic [KEY_W-1:0]   upd_key;
    logic [ST_W-1:0]    upd_status;

    lrp_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_ptr[IDX_W-1:0]),
        .o_rdata (rd_rec)
    );

    assign issue_rd  = i_cmd.scan && (r_rd_ptr != SCAN_W'(SLOTS));
    assign rec_key   = rd_rec[REC_W-1 -: KEY_W];
    assign rec_cnt   = rd_rec[STAMP_W +: CNT_W];
    assign rec_stamp = rd_rec[STAMP_W-1:0];
    assign rec_valid = r_slot_valid[r_dat_idx];

    // lowest count wins, then the older stamp; strict compare keeps lowest index
    assign take_best = rec_valid && (!r_best_found || (rec_cnt < r_best_cnt) ||
                       ((rec_cnt == r_best_cnt) && (rec_stamp < r_best_stamp)));

    assign o_stat.scan_done = (r_rd_ptr == SCAN_W'(SLOTS)) && r_dat_vld;

    assign cnt_next = (r_hit_cnt == CNT_MAX) ? r_hit_cnt : r_hit_cnt + 1'b1;

    always_comb begin
        we         = 1'b0;
        waddr      = r_hit_idx;
        wdata      = {r_key, cnt_next, r_stamp_ctr};
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        bump_stamp = 1'b0;
        upd_key    = '0;
        upd_status = ST_OK;
        case (r_op)
            OP_HIT: begin
                if (r_hit_found) begin
                    we         = 1'b1;
                    bump_stamp = 1'b1;
                end else begin
                    upd_status = ST_ABSENT;
                end
            end
            OP_INSERT: begin
                if (r_hit_found) begin
                    upd_status = ST_DUP;
                end else if (r_free_found) begin
                    we         = 1'b1;
                    waddr      = r_free_idx;
                    wdata      = {r_key, CNT_W'(1), r_stamp_ctr};
                    set_valid  = 1'b1;
                    bump_stamp = 1'b1;
                end else begin
                    upd_status = ST_FULL;
                end
            end
            OP_EVICT: begin
                if (r_best_found) begin
                    clr_valid = 1'b1;
                    upd_key   = r_best_key;
                end else begin
                    upd_status = ST_EMPTY;
                end
            end
            default: begin
                upd_status = ST_OK;
            end
        endcase
        if (!i_cmd.update) begin
            we         = 1'b0;
            set_valid  = 1'b0;
            clr_valid  = 1'b0;
            bump_stamp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_stamp_ctr  <= '0;
            r_dat_vld    <= 1'b0;
        end else begin
            if (set_valid) begin
                r_slot_valid[r_free_idx] <= 1'b1;
            end
            if (clr_valid) begin
                r_slot_valid[r_best_idx] <= 1'b0;
            end
            if (bump_stamp) begin
                r_stamp_ctr <= r_stamp_ctr + 1'b1;
            end
            r_dat_vld <= issue_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op         <= i_operation;
            r_key        <= i_key;
            r_rd_ptr     <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            if (issue_rd) begin
                r_rd_ptr  <= r_rd_ptr + 1'b1;
                r_dat_idx <= r_rd_ptr[IDX_W-1:0];
            end
            if (r_dat_vld) begin
                if (rec_valid && (rec_key == r_key) && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_idx   <= r_dat_idx;
                    r_hit_cnt   <= rec_cnt;
                end
                if (!rec_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_dat_idx;
                end
                if (take_best) begin
                    r_best_found <= 1'b1;
                    r_best_idx   <= r_dat_idx;
                    r_best_cnt   <= rec_cnt;
                    r_best_stamp <= rec_stamp;
                    r_best_key   <= rec_key;
                end
            end
        end
        if (i_cmd.update) begin
            r_res_key    <= upd_key;
            r_res_status <= upd_status;
        end
        if (i_cmd.load_out) begin
            r_out_key    <= r_res_key;
            r_out_status <= r_res_status;
        end
    end

    assign o_evicted_key = r_out_key;
    assign o_status      = r_out_status;

endmodule

`default_nettype wire

>>> src/lfu_replacement_policy_core.sv
// lfu replacement tracker: one input channel (operation, key), one result
// channel (evicted_key, status). Both use valid/stall; a word moves on an
// edge with valid high and stall low. Depends on lrp_pkg, lrp_ctrl, lrp_datapath.
//
// Each operation scans all SLOTS slot records in the record ram, one per
// cycle, looking for a key match, the lowest free slot and the eviction
// victim (lowest count, then oldest stamp, then lowest index). A word is
// taken only while idle; after acceptance the controller runs the scan
// (with a trailing step for the ram's registered read), one update step
// and one load into the output register, and the next word is taken only
// once it is back in idle. The ram scan takes most of this time.
// The result sits in an output register, so a new word is accepted while
// the previous result is still stalled; a finished result then waits in
// the datapath until the output register frees up.
// Reset clears all slot valid bits, the stamp counter and both valids; the
// record ram is not cleared, since only valid slots are ever used.
`timescale 1ns / 1ps
`default_nettype none

module lfu_replacement_policy_core
    import lrp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic      [KEY_W-1:0] o_evicted_key,
    output logic      [ST_W-1:0]  o_status
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .i_out_stall (i_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lrp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .o_evicted_key (o_evicted_key),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

>>> src/lrp_checker.sv
// port-level checks for the lfu replacement tracker, bound to the top level
// depends on lrp_pkg and lfu_replacement_policy_core
`timescale 1ns / 1ps
`default_nettype none

module lrp_checker
    import lrp_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_stall,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [KEY_W-1:0] o_evicted_key,
    input wire logic [ST_W-1:0]  o_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_evicted_key) && $stable(o_status)))
        else $error("stalled result word changed");

    // one word at a time: after acceptance the input is stalled
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting a word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_ABSENT || o_status == ST_FULL ||
                     o_status == ST_EMPTY || o_status == ST_DUP))
        else $error("result status out of range");

    // an error result never carries an evicted key
    a_err_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_evicted_key == '0))
        else $error("error result with nonzero evicted key");

endmodule

bind lfu_replacement_policy_core lrp_checker u_lrp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_evicted_key (o_evicted_key),
    .o_status      (o_status)
);

`default_nettype wire
